/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg
// Widths, constants and types shared by the cartesian-to-polar pipeline.
// ----------------------------------------------------------------------------
package c2p_pkg;

   localparam int POS_W           = 8;
   localparam int DIFF_W          = POS_W + 1;
   localparam int FRAC_W          = 16;
   localparam int XY_W            = 28;
   localparam int Z_W             = 26;
   localparam int GAIN_W          = 24;
   localparam int PROD_W          = (XY_W - 1) + GAIN_W;
   localparam int RAD_SHIFT       = 32;
   localparam int RADIUS_W        = 17;
   localparam int ANGLE_W         = 17;
   localparam int ANG_SHIFT       = 8;
   localparam int ATAN_ENTRIES    = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic [GAIN_W-1:0]    GAIN_Q24   = GAIN_W'(10188014);
   localparam logic signed [Z_W-1:0] DEG90_Q16 = Z_W'(5898240);
   localparam logic signed [Z_W-1:0] ANG_ROUND = Z_W'(128);
   localparam int                   ANGLE_MAX  = 46080;
   localparam int                   RADIUS_MAX = 131071;
   localparam logic [7:0]           CENTER_RST = 8'd50;

   // Arctangent of 2^-i in degrees, Q.16.
   localparam int ATAN_Q16 [ATAN_ENTRIES] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic                  zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } c2p_vec_type;

endpackage

/* sv/cartesian_to_polar_degrees_unit.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_degrees_unit
// Joystick position to radius and atan2 angle in degrees, CORDIC pipeline.
// ----------------------------------------------------------------------------
// Takes one request per cycle: an x/y byte pair from which the center register
// (reset 50) is subtracted. Returns the Euclidean radius (unsigned Q9.8) and
// the atan2 angle in degrees (signed Q9.8, -180.0..180.0, 0 for the center
// itself, +180.0 on the negative x axis). A request passes through one entry
// register that centers the vector and folds it into the right half plane,
// one cell per CORDIC micro-rotation, a gain multiply stage and the output
// register. Each stage stalls only when the stage after it is full, so gaps
// close up and a request is taken every cycle while results drain. Write the
// center register only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_polar_degrees_unit
   import c2p_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] x_pos, [15:8] y_pos
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] radius, [33:17] angle_deg, [39:34] zero
   // Center register
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // Center register
   logic [POS_W-1:0] center_ff;
   logic [POS_W-1:0] center_in;

   // Entry stage
   logic [POS_W-1:0]         x_pos;
   logic [POS_W-1:0]         y_pos;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [XY_W-1:0]   x0;
   logic signed [XY_W-1:0]   y0;
   c2p_vec_type              entry_in;

   // Chain links: index 0 is the entry register, index i+1 the output of cell i
   logic        link_valid [CORDIC_STAGES+1];
   logic        link_ready [CORDIC_STAGES+1];
   c2p_vec_type link_data  [CORDIC_STAGES+1];
   logic        entry_valid_ff;
   c2p_vec_type entry_ff;

   // Result fields
   logic [RADIUS_W-1:0]       radius;
   logic signed [ANGLE_W-1:0] angle_deg;

   assign x_pos = req_tdata[7:0];
   assign y_pos = req_tdata[15:8];

   // Hold the center; load on every write strobe
   assign center_in = csr_wr_en ? csr_wr_data : center_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RST;
      end else begin
         center_ff <= center_in;
      end
   end

   // Center both axes and scale to Q.16
   assign dx = $signed({1'b0, x_pos}) - $signed({1'b0, center_ff});
   assign dy = $signed({1'b0, y_pos}) - $signed({1'b0, center_ff});
   assign x0 = XY_W'(dx) <<< FRAC_W;
   assign y0 = XY_W'(dy) <<< FRAC_W;

   // Fold a left-half-plane vector by +/-90 degrees so the chain sees x >= 0
   always_comb begin
      entry_in.zero = (dx == '0) && (dy == '0);
      entry_in.x    = x0;
      entry_in.y    = y0;
      entry_in.z    = '0;
      if (dx[DIFF_W-1]) begin
         if (!dy[DIFF_W-1]) begin
            entry_in.x = y0;
            entry_in.y = -x0;
            entry_in.z = DEG90_Q16;
         end else begin
            entry_in.x = -y0;
            entry_in.y = x0;
            entry_in.z = -DEG90_Q16;
         end
      end
   end

   // Entry register: advance when empty or when the first cell takes its request
   assign req_tready = !entry_valid_ff || link_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (req_tready) begin
         entry_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         entry_ff <= entry_in;
      end
   end

   assign link_valid[0] = entry_valid_ff;
   assign link_data[0]  = entry_ff;

   // One cell per micro-rotation, each handing its vector to the next
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      c2p_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Gain correction, rounding, clamping and the output register
   c2p_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[CORDIC_STAGES]),
      .in_ready  (link_ready[CORDIC_STAGES]),
      .in_data   (link_data[CORDIC_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .radius    (radius),
      .angle_deg (angle_deg)
   );

   assign rsp_tdata = {6'b0, angle_deg, radius};

   // A free output must leave every stage free to move
   `ASSERT_ALWAYS(a_no_stall_when_free,
      (rsp_tvalid && !rsp_tready) || req_tready, "request stalled with output free")
   // A request on the center itself is marked as the zero vector
   `ASSERT_NEXT(a_zero_flag,
      req_tvalid && req_tready && x_pos == center_ff && y_pos == center_ff,
      entry_valid_ff && entry_ff.zero, "center request not flagged")
   // Angle stays within plus/minus 180 degrees
   `ASSERT_ALWAYS(a_angle_range,
      !rsp_tvalid || (angle_deg <= 17'sd46080 && angle_deg >= -17'sd46080),
      "angle out of range")

endmodule

/* sv/c2p_cell.sv */
// ----------------------------------------------------------------------------
// c2p_cell
// One CORDIC vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module c2p_cell
   import c2p_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  c2p_vec_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output c2p_vec_type out_data
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q16[IDX]);

   logic                   valid_ff;
   c2p_vec_type            data_ff;
   c2p_vec_type            data_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign xs = in_data.x >>> IDX;
   assign ys = in_data.y >>> IDX;

   // Drive y toward zero; accumulate the angle taken.
   always_comb begin
      data_in      = in_data;
      if (!in_data.y[XY_W-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* sv/c2p_post.sv */
// ----------------------------------------------------------------------------
// c2p_post
// Gain correction, rounding and clamping of the CORDIC result.
// ----------------------------------------------------------------------------
module c2p_post
   import c2p_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  c2p_vec_type                in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [RADIUS_W-1:0]        radius,
   output logic signed [ANGLE_W-1:0]  angle_deg
);

   localparam int RAD_FULL_W = PROD_W + 1 - RAD_SHIFT;

   // Stage A: product and angle
   logic                       a_valid_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;
   logic signed [ANGLE_W-1:0]  ang_ff;
   logic signed [ANGLE_W-1:0]  ang_in;
   logic                       a_ready;
   logic [XY_W-2:0]            x_clamp;
   logic signed [Z_W-1:0]      z_round;

   // Stage B: output register
   logic                       b_valid_ff;
   logic [RADIUS_W-1:0]        rad_ff;
   logic [RADIUS_W-1:0]        rad_in;
   logic signed [ANGLE_W-1:0]  ang_out_ff;
   logic                       b_ready;
   logic [PROD_W:0]            rad_sum;
   logic [RAD_FULL_W-1:0]      rad_full;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign x_clamp = in_data.x[XY_W-1] ? '0 : in_data.x[XY_W-2:0];
   assign z_round = (in_data.z + ANG_ROUND) >>> ANG_SHIFT;

   always_comb begin
      prod_in = PROD_W'(x_clamp) * PROD_W'(GAIN_Q24);
      if (z_round > Z_W'(ANGLE_MAX)) begin
         ang_in = ANGLE_W'(ANGLE_MAX);
      end else if (z_round < -Z_W'(ANGLE_MAX)) begin
         ang_in = -ANGLE_W'(ANGLE_MAX);
      end else begin
         ang_in = z_round[ANGLE_W-1:0];
      end
      // Zero vector: force both results to zero
      if (in_data.zero) begin
         prod_in = '0;
         ang_in  = '0;
      end
   end

   assign rad_sum  = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (RAD_SHIFT - 1));
   assign rad_full = rad_sum[PROD_W:RAD_SHIFT];
   assign rad_in   = (rad_full > RAD_FULL_W'(RADIUS_MAX)) ? RADIUS_W'(RADIUS_MAX)
                                                         : rad_full[RADIUS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         prod_ff <= prod_in;
         ang_ff  <= ang_in;
      end
      if (b_ready && a_valid_ff) begin
         rad_ff     <= rad_in;
         ang_out_ff <= ang_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign radius    = rad_ff;
   assign angle_deg = ang_out_ff;

endmodule
